// File: hdl/evts_pkg.sv
// Shared types and constants for the tractive system sequencer.
package evts_pkg;

   localparam int TIME_W = 16;
   localparam int VOLT_W = 13;
   localparam int FILL_W = 10;
   localparam int SEV_W  = 2;
   localparam int RHS_W  = FILL_W + VOLT_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [VOLT_W-1:0] PACK_GUARD_DV = 13'd100;

   typedef enum logic [2:0] {
      MODE_INIT      = 3'd0,
      MODE_LV_READY  = 3'd1,
      MODE_PRECHARGE = 3'd2,
      MODE_TS_ACTIVE = 3'd3,
      MODE_RTD_WAIT  = 3'd4,
      MODE_DRIVE     = 3'd5,
      MODE_FAULT     = 3'd6,
      MODE_SHUTDOWN  = 3'd7
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_RISE_CHECK_DELAY  = 3'd0,
      REG_MIN_RISE          = 3'd1,
      REG_TARGET_FILL       = 3'd2,
      REG_PRECHARGE_TIMEOUT = 3'd3,
      REG_BUZZER_HOLD       = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [TIME_W-1:0] rise_check_delay_ms;
      logic [VOLT_W-1:0] min_rise_decivolts;
      logic [FILL_W-1:0] target_fill_permille;
      logic [TIME_W-1:0] pc_timeout_ms;
      logic [TIME_W-1:0] buzzer_hold_ms;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0] tick_ms;
      logic              bms_alive;
      logic              inverter_alive;
      logic [VOLT_W-1:0] link_now;
      logic              hv_request;
      logic              shutdown_loop_ok;
      logic              ready_button;
      logic              brake_pressed;
      logic [SEV_W-1:0]  fault_severity;
   } beat_type;

   typedef struct packed {
      mode_type          mode;
      logic              just_entered;
      logic [TIME_W-1:0] mode_time_ms;
      logic [VOLT_W-1:0] start_link_voltage;
      logic              rise_checked;
      logic [TIME_W-1:0] hold_time_ms;
   } state_type;

   typedef struct packed {
      logic [2:0] mode_code;
      logic       air_negative;
      logic       air_positive;
      logic       precharge_drive;
      logic       buzzer_on;
      logic       shutdown_out;
      logic       drive_enable;
      logic       no_rise_report;
      logic       timeout_report;
   } result_type;

endpackage

// File: hdl/evts_step.sv
// One control tick of the sequencer: next state and decoded result.
module evts_step #(
   parameter int SHUTDOWN_HOLD_MS = 500
) (
   input  evts_pkg::state_type  state_cur,
   input  evts_pkg::beat_type   beat,
   input  evts_pkg::cfg_type    cfg,
   input  logic                 fill_met,
   output evts_pkg::state_type  state_next,
   output evts_pkg::result_type result
);

   logic no_rise;
   logic timeout;

   always_comb begin
      logic [evts_pkg::TIME_W:0]   mt_sum;
      logic [evts_pkg::TIME_W:0]   hold_sum;
      logic [evts_pkg::VOLT_W:0]   rise_limit;
      logic                        go;
      evts_pkg::mode_type          go_mode;
      logic                        rc_cur;
      logic [evts_pkg::VOLT_W-1:0] start_cur;

      state_next = state_cur;
      state_next.just_entered = 1'b0;
      no_rise = 1'b0;
      timeout = 1'b0;
      go = 1'b0;
      go_mode = state_cur.mode;

      mt_sum = {1'b0, state_cur.mode_time_ms} + {1'b0, beat.tick_ms};
      state_next.mode_time_ms = mt_sum[evts_pkg::TIME_W] ? '1 :
                                mt_sum[evts_pkg::TIME_W-1:0];
      hold_sum = {1'b0, state_cur.hold_time_ms} + {1'b0, beat.tick_ms};

      rc_cur = state_cur.rise_checked;
      start_cur = state_cur.start_link_voltage;
      rise_limit = '0;

      if (beat.fault_severity[1] && state_cur.mode != evts_pkg::MODE_FAULT &&
          state_cur.mode != evts_pkg::MODE_SHUTDOWN) begin
         go = 1'b1;
         go_mode = evts_pkg::MODE_FAULT;
      end else begin
         case (state_cur.mode)
            evts_pkg::MODE_INIT: begin
               if (beat.bms_alive && beat.inverter_alive) begin
                  go = 1'b1;
                  go_mode = evts_pkg::MODE_LV_READY;
               end
            end
            evts_pkg::MODE_LV_READY: begin
               if (beat.hv_request && beat.shutdown_loop_ok &&
                   beat.fault_severity == '0) begin
                  go = 1'b1;
                  go_mode = evts_pkg::MODE_PRECHARGE;
               end
            end
            evts_pkg::MODE_PRECHARGE: begin
               if (state_cur.just_entered) begin
                  start_cur = beat.link_now;
                  rc_cur = 1'b0;
               end
               state_next.start_link_voltage = start_cur;
               state_next.rise_checked = rc_cur;
               rise_limit = {1'b0, start_cur} + {1'b0, cfg.min_rise_decivolts};
               if (!rc_cur && state_next.mode_time_ms >= cfg.rise_check_delay_ms) begin
                  state_next.rise_checked = 1'b1;
                  no_rise = {1'b0, beat.link_now} < rise_limit;
               end
               if (fill_met) begin
                  go = 1'b1;
                  go_mode = evts_pkg::MODE_TS_ACTIVE;
               end else if (state_next.mode_time_ms >= cfg.pc_timeout_ms) begin
                  timeout = 1'b1;
               end
               if (!beat.hv_request) begin
                  go = 1'b1;
                  go_mode = evts_pkg::MODE_LV_READY;
               end
            end
            evts_pkg::MODE_TS_ACTIVE: begin
               go = 1'b1;
               go_mode = beat.hv_request ? evts_pkg::MODE_RTD_WAIT :
                                           evts_pkg::MODE_SHUTDOWN;
            end
            evts_pkg::MODE_RTD_WAIT: begin
               if (!beat.hv_request) begin
                  go = 1'b1;
                  go_mode = evts_pkg::MODE_SHUTDOWN;
               end else if (beat.brake_pressed && beat.ready_button) begin
                  state_next.hold_time_ms = hold_sum[evts_pkg::TIME_W] ? '1 :
                                            hold_sum[evts_pkg::TIME_W-1:0];
                  if (state_next.hold_time_ms >= cfg.buzzer_hold_ms) begin
                     go = 1'b1;
                     go_mode = evts_pkg::MODE_DRIVE;
                  end
               end else begin
                  state_next.hold_time_ms = '0;
               end
            end
            evts_pkg::MODE_DRIVE: begin
               if (!beat.hv_request) begin
                  go = 1'b1;
                  go_mode = evts_pkg::MODE_SHUTDOWN;
               end
            end
            evts_pkg::MODE_FAULT: begin
               if (!beat.fault_severity[1] && !beat.hv_request) begin
                  go = 1'b1;
                  go_mode = evts_pkg::MODE_LV_READY;
               end
            end
            default: begin
               if (state_next.mode_time_ms > evts_pkg::TIME_W'(SHUTDOWN_HOLD_MS)) begin
                  go = 1'b1;
                  go_mode = evts_pkg::MODE_LV_READY;
               end
            end
         endcase
      end

      if (go && go_mode != state_cur.mode) begin
         state_next.mode = go_mode;
         state_next.just_entered = 1'b1;
         state_next.mode_time_ms = '0;
         state_next.hold_time_ms = '0;
      end
   end

   always_comb begin
      result.mode_code = state_next.mode;
      result.air_negative = state_next.mode == evts_pkg::MODE_PRECHARGE ||
                            state_next.mode == evts_pkg::MODE_TS_ACTIVE ||
                            state_next.mode == evts_pkg::MODE_RTD_WAIT ||
                            state_next.mode == evts_pkg::MODE_DRIVE;
      result.air_positive = state_next.mode == evts_pkg::MODE_TS_ACTIVE ||
                            state_next.mode == evts_pkg::MODE_RTD_WAIT ||
                            state_next.mode == evts_pkg::MODE_DRIVE;
      result.precharge_drive = state_next.mode == evts_pkg::MODE_PRECHARGE;
      result.buzzer_on = state_next.mode == evts_pkg::MODE_RTD_WAIT &&
                         state_next.hold_time_ms != '0;
      result.shutdown_out = state_next.mode == evts_pkg::MODE_FAULT;
      result.drive_enable = state_next.mode == evts_pkg::MODE_DRIVE;
      result.no_rise_report = no_rise;
      result.timeout_report = timeout;
   end

endmodule

// File: hdl/ev_tractive_system_sequencer.sv
// Top level of the tractive system sequencer: beat pipeline, registers and state.
//
//   Channel  Direction  Handshake           Carries
//   req_     in         req_valid/req_stall one control tick
//   rsp_     out        rsp_valid/rsp_stall new mode and drive outputs
//   csr_     in         csr_valid/csr_ready register index and write data
//
// One beat can be accepted in every cycle while req_stall is low.
// The first stage registers the tick and the two fill products; the second compares
// them and updates the sequence state into the result register.
// Reset is synchronous; it loads the register defaults and the initial state and
// clears both valid flags.
// A stalled result holds the pipeline, and req_stall rises only while both stages are full.
module ev_tractive_system_sequencer #(
   parameter int FULL_SCALE_PERMILLE = 1000,
   parameter int SHUTDOWN_HOLD_MS    = 500
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [evts_pkg::TIME_W-1:0]        req_tick_ms,
   input  logic                               req_bms_alive,
   input  logic                               req_inverter_alive,
   input  logic [evts_pkg::VOLT_W-1:0]        req_pack_decivolts,
   input  logic [evts_pkg::VOLT_W-1:0]        req_link_decivolts,
   input  logic                               req_hv_request,
   input  logic                               req_shutdown_loop_ok,
   input  logic                               req_ready_button,
   input  logic                               req_brake_pressed,
   input  logic [evts_pkg::SEV_W-1:0]         req_fault_severity,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [2:0]                         rsp_mode_code,
   output logic                               rsp_air_negative,
   output logic                               rsp_air_positive,
   output logic                               rsp_precharge_drive,
   output logic                               rsp_buzzer_on,
   output logic                               rsp_shutdown_out,
   output logic                               rsp_drive_enable,
   output logic                               rsp_no_rise_report,
   output logic                               rsp_timeout_report,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [evts_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [evts_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int LHS_W = evts_pkg::VOLT_W + $clog2(FULL_SCALE_PERMILLE + 1);
   localparam int MUL_W = (LHS_W > evts_pkg::RHS_W) ? LHS_W : evts_pkg::RHS_W;

   evts_pkg::cfg_type    cfg_ff;
   evts_pkg::beat_type   beat_ff;
   evts_pkg::beat_type   beat_in;
   evts_pkg::state_type  state_ff;
   evts_pkg::state_type  state_in;
   evts_pkg::result_type result_ff;
   evts_pkg::result_type result_in;
   logic [MUL_W-1:0]     lhs_ff;
   logic [MUL_W-1:0]     lhs_in;
   logic [MUL_W-1:0]     rhs_ff;
   logic [MUL_W-1:0]     rhs_in;
   logic                 s1_valid_ff;
   logic                 rsp_valid_ff;
   logic                 s1_adv;
   logic                 req_accept;
   logic                 fill_met;

   assign csr_ready  = 1'b1;
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_adv;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rise_check_delay_ms  <= 16'd500;
         cfg_ff.min_rise_decivolts   <= 13'd100;
         cfg_ff.target_fill_permille <= 10'd950;
         cfg_ff.pc_timeout_ms        <= 16'd5000;
         cfg_ff.buzzer_hold_ms       <= 16'd1000;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            evts_pkg::REG_RISE_CHECK_DELAY:  cfg_ff.rise_check_delay_ms <= csr_data;
            evts_pkg::REG_MIN_RISE:
               cfg_ff.min_rise_decivolts <= csr_data[evts_pkg::VOLT_W-1:0];
            evts_pkg::REG_TARGET_FILL:
               cfg_ff.target_fill_permille <= csr_data[evts_pkg::FILL_W-1:0];
            evts_pkg::REG_PRECHARGE_TIMEOUT: cfg_ff.pc_timeout_ms <= csr_data;
            evts_pkg::REG_BUZZER_HOLD:       cfg_ff.buzzer_hold_ms <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      beat_in.tick_ms          = req_tick_ms;
      beat_in.bms_alive        = req_bms_alive;
      beat_in.inverter_alive   = req_inverter_alive;
      beat_in.link_now         = req_inverter_alive ? req_link_decivolts : '0;
      beat_in.hv_request       = req_hv_request;
      beat_in.shutdown_loop_ok = req_shutdown_loop_ok;
      beat_in.ready_button     = req_ready_button;
      beat_in.brake_pressed    = req_brake_pressed;
      beat_in.fault_severity   = req_fault_severity;
      if (req_inverter_alive && req_bms_alive &&
          req_pack_decivolts >= evts_pkg::PACK_GUARD_DV) begin
         lhs_in = MUL_W'(req_link_decivolts) * MUL_W'(FULL_SCALE_PERMILLE);
         rhs_in = MUL_W'(cfg_ff.target_fill_permille) * MUL_W'(req_pack_decivolts);
      end else begin
         lhs_in = '0;
         rhs_in = MUL_W'(cfg_ff.target_fill_permille);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         beat_ff <= beat_in;
         lhs_ff  <= lhs_in;
         rhs_ff  <= rhs_in;
      end
   end

   assign fill_met = lhs_ff >= rhs_ff;

   evts_step #(
      .SHUTDOWN_HOLD_MS(SHUTDOWN_HOLD_MS)
   ) u_step (
      .state_cur (state_ff),
      .beat      (beat_ff),
      .cfg       (cfg_ff),
      .fill_met  (fill_met),
      .state_next(state_in),
      .result    (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode               <= evts_pkg::MODE_INIT;
         state_ff.just_entered       <= 1'b1;
         state_ff.mode_time_ms       <= '0;
         state_ff.start_link_voltage <= '0;
         state_ff.rise_checked       <= 1'b0;
         state_ff.hold_time_ms       <= '0;
      end else if (s1_adv) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mode_code       = result_ff.mode_code;
   assign rsp_air_negative    = result_ff.air_negative;
   assign rsp_air_positive    = result_ff.air_positive;
   assign rsp_precharge_drive = result_ff.precharge_drive;
   assign rsp_buzzer_on       = result_ff.buzzer_on;
   assign rsp_shutdown_out    = result_ff.shutdown_out;
   assign rsp_drive_enable    = result_ff.drive_enable;
   assign rsp_no_rise_report  = result_ff.no_rise_report;
   assign rsp_timeout_report  = result_ff.timeout_report;

   a_s1_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff)
      else $error("A held first-stage beat was dropped.");

   a_state_frozen: assert property (@(posedge clock) disable iff (reset)
      !s1_adv |=> $stable(state_ff))
      else $error("Sequence state changed without a beat.");

   a_entry_flag: assert property (@(posedge clock) disable iff (reset)
      s1_adv && state_in.mode != state_ff.mode |=> state_ff.just_entered)
      else $error("A mode change did not mark the new mode as just entered.");

   a_timeout_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_timeout_report |->
         (rsp_mode_code == evts_pkg::MODE_PRECHARGE ||
          rsp_mode_code == evts_pkg::MODE_LV_READY))
      else $error("A timeout was reported outside precharge.");

endmodule

// File: tb/evts_checker.sv
// Checker for the tractive system sequencer: watches all channels, predicts each result and compares.
module evts_checker #(
   parameter int FULL_SCALE_PERMILLE = 1000,
   parameter int SHUTDOWN_HOLD_MS    = 500
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [evts_pkg::TIME_W-1:0]      req_tick_ms,
   input  logic                             req_bms_alive,
   input  logic                             req_inverter_alive,
   input  logic [evts_pkg::VOLT_W-1:0]      req_pack_decivolts,
   input  logic [evts_pkg::VOLT_W-1:0]      req_link_decivolts,
   input  logic                             req_hv_request,
   input  logic                             req_shutdown_loop_ok,
   input  logic                             req_ready_button,
   input  logic                             req_brake_pressed,
   input  logic [evts_pkg::SEV_W-1:0]       req_fault_severity,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [2:0]                       rsp_mode_code,
   input  logic                             rsp_air_negative,
   input  logic                             rsp_air_positive,
   input  logic                             rsp_precharge_drive,
   input  logic                             rsp_buzzer_on,
   input  logic                             rsp_shutdown_out,
   input  logic                             rsp_drive_enable,
   input  logic                             rsp_no_rise_report,
   input  logic                             rsp_timeout_report,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [evts_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [evts_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                               fail_count,
   output int                               pending,
   output int                               results_checked
);

   evts_pkg::cfg_type           cfg;
   evts_pkg::mode_type          seq_mode;
   logic                        seq_just_entered;
   logic [evts_pkg::TIME_W-1:0] seq_mode_time;
   logic [evts_pkg::TIME_W-1:0] seq_hold_time;
   logic [evts_pkg::VOLT_W-1:0] seq_start_link;
   logic                        seq_rise_checked;
   evts_pkg::result_type        expected_results[$];

   initial begin
      fail_count = 0;
      pending = 0;
      results_checked = 0;
   end

   function automatic logic [evts_pkg::TIME_W-1:0] sat_add(logic [evts_pkg::TIME_W-1:0] a,
                                                            logic [evts_pkg::TIME_W-1:0] b);
      logic [evts_pkg::TIME_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[evts_pkg::TIME_W] ? {evts_pkg::TIME_W{1'b1}} : sum[evts_pkg::TIME_W-1:0];
   endfunction

   function automatic void change_mode(evts_pkg::mode_type next);
      if (next != seq_mode) begin
         seq_mode = next;
         seq_just_entered = 1'b1;
         seq_mode_time = '0;
         seq_hold_time = '0;
      end
   endfunction

   function automatic evts_pkg::result_type predict_tick();
      logic                        critical;
      logic                        entering;
      logic                        no_rise;
      logic                        timed_out;
      logic [evts_pkg::VOLT_W-1:0] link_now;
      logic [31:0]                 fill_lhs;
      logic [31:0]                 fill_rhs;
      evts_pkg::result_type        r;
      critical = req_fault_severity >= 2;
      entering = seq_just_entered;
      no_rise = 1'b0;
      timed_out = 1'b0;
      link_now = req_inverter_alive ? req_link_decivolts : '0;
      seq_just_entered = 1'b0;
      seq_mode_time = sat_add(seq_mode_time, req_tick_ms);
      if (critical && seq_mode != evts_pkg::MODE_FAULT &&
          seq_mode != evts_pkg::MODE_SHUTDOWN) begin
         change_mode(evts_pkg::MODE_FAULT);
      end else begin
         case (seq_mode)
            evts_pkg::MODE_INIT: begin
               if (req_bms_alive && req_inverter_alive) change_mode(evts_pkg::MODE_LV_READY);
            end
            evts_pkg::MODE_LV_READY: begin
               if (req_hv_request && req_shutdown_loop_ok && req_fault_severity == 0)
                  change_mode(evts_pkg::MODE_PRECHARGE);
            end
            evts_pkg::MODE_PRECHARGE: begin
               if (entering) begin
                  seq_start_link = link_now;
                  seq_rise_checked = 1'b0;
               end
               if (!seq_rise_checked && seq_mode_time >= cfg.rise_check_delay_ms) begin
                  seq_rise_checked = 1'b1;
                  if (32'(link_now) < 32'(seq_start_link) + 32'(cfg.min_rise_decivolts))
                     no_rise = 1'b1;
               end
               if (req_inverter_alive && req_bms_alive &&
                   req_pack_decivolts >= evts_pkg::PACK_GUARD_DV) begin
                  fill_lhs = 32'(req_link_decivolts) * 32'(FULL_SCALE_PERMILLE);
                  fill_rhs = 32'(cfg.target_fill_permille) * 32'(req_pack_decivolts);
               end else begin
                  fill_lhs = '0;
                  fill_rhs = 32'(cfg.target_fill_permille);
               end
               if (fill_lhs >= fill_rhs) change_mode(evts_pkg::MODE_TS_ACTIVE);
               else if (seq_mode_time >= cfg.pc_timeout_ms) timed_out = 1'b1;
               if (!req_hv_request) change_mode(evts_pkg::MODE_LV_READY);
            end
            evts_pkg::MODE_TS_ACTIVE: begin
               if (req_hv_request) change_mode(evts_pkg::MODE_RTD_WAIT);
               else change_mode(evts_pkg::MODE_SHUTDOWN);
            end
            evts_pkg::MODE_RTD_WAIT: begin
               if (!req_hv_request) begin
                  change_mode(evts_pkg::MODE_SHUTDOWN);
               end else if (req_brake_pressed && req_ready_button) begin
                  seq_hold_time = sat_add(seq_hold_time, req_tick_ms);
                  if (seq_hold_time >= cfg.buzzer_hold_ms) change_mode(evts_pkg::MODE_DRIVE);
               end else begin
                  seq_hold_time = '0;
               end
            end
            evts_pkg::MODE_DRIVE: begin
               if (!req_hv_request) change_mode(evts_pkg::MODE_SHUTDOWN);
            end
            evts_pkg::MODE_FAULT: begin
               if (!critical && !req_hv_request) change_mode(evts_pkg::MODE_LV_READY);
            end
            default: begin
               if (32'(seq_mode_time) > 32'(SHUTDOWN_HOLD_MS))
                  change_mode(evts_pkg::MODE_LV_READY);
            end
         endcase
      end
      r.mode_code = seq_mode;
      r.air_negative = seq_mode >= evts_pkg::MODE_PRECHARGE && seq_mode <= evts_pkg::MODE_DRIVE;
      r.air_positive = seq_mode >= evts_pkg::MODE_TS_ACTIVE && seq_mode <= evts_pkg::MODE_DRIVE;
      r.precharge_drive = seq_mode == evts_pkg::MODE_PRECHARGE;
      r.buzzer_on = seq_mode == evts_pkg::MODE_RTD_WAIT && seq_hold_time != 0;
      r.shutdown_out = seq_mode == evts_pkg::MODE_FAULT;
      r.drive_enable = seq_mode == evts_pkg::MODE_DRIVE;
      r.no_rise_report = no_rise;
      r.timeout_report = timed_out;
      return r;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      evts_pkg::result_type want;
      if (reset) begin
         cfg.rise_check_delay_ms = 16'd500;
         cfg.min_rise_decivolts = 13'd100;
         cfg.target_fill_permille = 10'd950;
         cfg.pc_timeout_ms = 16'd5000;
         cfg.buzzer_hold_ms = 16'd1000;
         seq_mode = evts_pkg::MODE_INIT;
         seq_just_entered = 1'b1;
         seq_mode_time = '0;
         seq_hold_time = '0;
         seq_start_link = '0;
         seq_rise_checked = 1'b0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: result beat with nothing expected, got mode %0d",
                        $time, rsp_mode_code);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("mode_code", want.mode_code, rsp_mode_code);
               check_field("air_negative", want.air_negative, rsp_air_negative);
               check_field("air_positive", want.air_positive, rsp_air_positive);
               check_field("precharge_drive", want.precharge_drive, rsp_precharge_drive);
               check_field("buzzer_on", want.buzzer_on, rsp_buzzer_on);
               check_field("shutdown_out", want.shutdown_out, rsp_shutdown_out);
               check_field("drive_enable", want.drive_enable, rsp_drive_enable);
               check_field("no_rise_report", want.no_rise_report, rsp_no_rise_report);
               check_field("timeout_report", want.timeout_report, rsp_timeout_report);
               results_checked++;
            end
         end
         if (req_valid && !req_stall) expected_results.push_back(predict_tick());
         if (csr_valid && csr_ready) begin
            case (csr_index)
               evts_pkg::REG_RISE_CHECK_DELAY:  cfg.rise_check_delay_ms = csr_data;
               evts_pkg::REG_MIN_RISE:
                  cfg.min_rise_decivolts = csr_data[evts_pkg::VOLT_W-1:0];
               evts_pkg::REG_TARGET_FILL:
                  cfg.target_fill_permille = csr_data[evts_pkg::FILL_W-1:0];
               evts_pkg::REG_PRECHARGE_TIMEOUT: cfg.pc_timeout_ms = csr_data;
               evts_pkg::REG_BUZZER_HOLD:       cfg.buzzer_hold_ms = csr_data;
               default: ;
            endcase
         end
      end
      pending = expected_results.size();
   end

endmodule

// File: tb/tb_top.sv
// Testbench top for the tractive system sequencer: clock, reset, stimulus and verdict.
module tb_top;

   typedef struct {
      logic [evts_pkg::TIME_W-1:0] tick_ms;
      logic                        bms;
      logic                        inv;
      logic [evts_pkg::VOLT_W-1:0] pack;
      logic [evts_pkg::VOLT_W-1:0] link;
      logic                        hv;
      logic                        loop_ok;
      logic                        button;
      logic                        brake;
      logic [evts_pkg::SEV_W-1:0]  sev;
   } tick_type;

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [evts_pkg::TIME_W-1:0]      req_tick_ms;
   logic                             req_bms_alive;
   logic                             req_inverter_alive;
   logic [evts_pkg::VOLT_W-1:0]      req_pack_decivolts;
   logic [evts_pkg::VOLT_W-1:0]      req_link_decivolts;
   logic                             req_hv_request;
   logic                             req_shutdown_loop_ok;
   logic                             req_ready_button;
   logic                             req_brake_pressed;
   logic [evts_pkg::SEV_W-1:0]       req_fault_severity;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic [2:0]                       rsp_mode_code;
   logic                             rsp_air_negative;
   logic                             rsp_air_positive;
   logic                             rsp_precharge_drive;
   logic                             rsp_buzzer_on;
   logic                             rsp_shutdown_out;
   logic                             rsp_drive_enable;
   logic                             rsp_no_rise_report;
   logic                             rsp_timeout_report;
   logic                             csr_valid;
   logic                             csr_ready;
   logic [evts_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [evts_pkg::CSR_DATA_W-1:0]  csr_data;
   int                               fail_count;
   int                               pending;
   int                               results_checked;

   int ticks_sent = 0;
   int settings_applied = 0;
   bit no_gaps = 1'b0;

   bit want_hv = 1'b1;
   bit hold_brake = 1'b0;
   bit hold_button = 1'b0;
   int pack_level = 4000;
   int link_level = 0;
   int ramp_div = 8;

   ev_tractive_system_sequencer dut (.*);
   evts_checker u_checker (.*);

   always #1 clock = ~clock;

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

   initial begin : stall_gen
      int quiet;
      int busy;
      rsp_stall = 1'b0;
      forever begin
         quiet = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 12);
         rsp_stall = 1'b0;
         repeat (quiet) @(negedge clock);
         busy = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
         rsp_stall = 1'b1;
         repeat (busy) @(negedge clock);
      end
   end

   function automatic tick_type mk(int tick, int bms, int inv, int pack, int link, int hv,
                                   int loop_ok, int button, int brake, int sev);
      tick_type t;
      t.tick_ms = tick[evts_pkg::TIME_W-1:0];
      t.bms = bms[0];
      t.inv = inv[0];
      t.pack = pack[evts_pkg::VOLT_W-1:0];
      t.link = link[evts_pkg::VOLT_W-1:0];
      t.hv = hv[0];
      t.loop_ok = loop_ok[0];
      t.button = button[0];
      t.brake = brake[0];
      t.sev = sev[evts_pkg::SEV_W-1:0];
      return t;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic tick_type random_tick();
      tick_type t;
      int r;
      int step;
      int ms;
      if ($urandom_range(0, 99) < 6) begin
         return mk($urandom_range(0, 65535), $urandom_range(0, 1), $urandom_range(0, 1),
                   $urandom_range(0, 8000), $urandom_range(0, 8000), $urandom_range(0, 1),
                   $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                   $urandom_range(0, 3));
      end
      if ($urandom_range(0, 99) < 3) want_hv = !want_hv;
      if ($urandom_range(0, 9) == 0) hold_brake = !hold_brake;
      if ($urandom_range(0, 9) == 0) hold_button = !hold_button;
      if (!want_hv) begin
         link_level = link_level / 2;
         if ($urandom_range(0, 3) == 0) begin
            pack_level = $urandom_range(90, 8000);
            ramp_div = $urandom_range(2, 64);
         end
      end else begin
         step = $urandom_range(0, pack_level / ramp_div);
         link_level = link_level + step;
         if (link_level > pack_level + 50) link_level = pack_level + 50;
         if (link_level > 8000) link_level = 8000;
      end
      t.bms = $urandom_range(0, 49) != 0;
      t.inv = $urandom_range(0, 49) != 0;
      t.loop_ok = $urandom_range(0, 24) != 0;
      t.hv = want_hv;
      t.brake = hold_brake;
      t.button = hold_button;
      t.pack = pack_level[evts_pkg::VOLT_W-1:0];
      t.link = link_level[evts_pkg::VOLT_W-1:0];
      r = $urandom_range(0, 199);
      if (r < 186) t.sev = 2'd0;
      else if (r < 194) t.sev = 2'd1;
      else if (r < 198) t.sev = 2'd2;
      else t.sev = 2'd3;
      r = $urandom_range(0, 99);
      if (r < 85) ms = $urandom_range(0, 40);
      else if (r < 95) ms = $urandom_range(0, 1500);
      else ms = $urandom_range(0, 65535);
      t.tick_ms = ms[evts_pkg::TIME_W-1:0];
      return t;
   endfunction

   task automatic send_tick(tick_type t, int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tick_ms = t.tick_ms;
      req_bms_alive = t.bms;
      req_inverter_alive = t.inv;
      req_pack_decivolts = t.pack;
      req_link_decivolts = t.link;
      req_hv_request = t.hv;
      req_shutdown_loop_ok = t.loop_ok;
      req_ready_button = t.button;
      req_brake_pressed = t.brake;
      req_fault_severity = t.sev;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ticks_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(evts_pkg::reg_index_type idx,
                            logic [evts_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic apply_config(int delay, int min_rise, int fill, int timeout, int hold);
      write_reg(evts_pkg::REG_RISE_CHECK_DELAY, delay[evts_pkg::CSR_DATA_W-1:0]);
      write_reg(evts_pkg::REG_MIN_RISE, min_rise[evts_pkg::CSR_DATA_W-1:0]);
      write_reg(evts_pkg::REG_TARGET_FILL, fill[evts_pkg::CSR_DATA_W-1:0]);
      write_reg(evts_pkg::REG_PRECHARGE_TIMEOUT, timeout[evts_pkg::CSR_DATA_W-1:0]);
      write_reg(evts_pkg::REG_BUZZER_HOLD, hold[evts_pkg::CSR_DATA_W-1:0]);
      settings_applied++;
   endtask

   initial begin
      tick_type directed[$];
      reset = 1'b1;
      req_valid = 1'b0;
      req_tick_ms = '0;
      req_bms_alive = 1'b0;
      req_inverter_alive = 1'b0;
      req_pack_decivolts = '0;
      req_link_decivolts = '0;
      req_hv_request = 1'b0;
      req_shutdown_loop_ok = 1'b0;
      req_ready_button = 1'b0;
      req_brake_pressed = 1'b0;
      req_fault_severity = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      apply_config(10, 100, 950, 30, 20);
      directed.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk(65535, 1, 0, 8000, 8000, 1, 1, 1, 1, 1));
      directed.push_back(mk(5, 1, 1, 4000, 0, 1, 1, 0, 0, 1));
      directed.push_back(mk(5, 1, 1, 4000, 0, 1, 1, 0, 0, 1));
      directed.push_back(mk(5, 1, 1, 4000, 0, 1, 0, 0, 0, 0));
      directed.push_back(mk(5, 1, 1, 4000, 0, 1, 1, 0, 0, 0));
      directed.push_back(mk(5, 1, 1, 4000, 0, 1, 1, 0, 0, 0));
      directed.push_back(mk(10, 1, 1, 4000, 50, 1, 1, 0, 0, 0));
      directed.push_back(mk(20, 1, 1, 4000, 60, 0, 1, 0, 0, 0));
      directed.push_back(mk(1, 1, 1, 4000, 60, 1, 1, 0, 0, 0));
      directed.push_back(mk(1, 1, 0, 4000, 7000, 1, 1, 0, 0, 0));
      directed.push_back(mk(1, 0, 1, 4000, 4000, 1, 1, 0, 0, 0));
      directed.push_back(mk(1, 1, 1, 99, 99, 1, 1, 0, 0, 0));
      directed.push_back(mk(20, 1, 1, 4000, 3800, 1, 1, 0, 0, 0));
      directed.push_back(mk(1, 1, 1, 4000, 3800, 1, 1, 0, 0, 0));
      directed.push_back(mk(10, 1, 1, 4000, 3800, 1, 1, 1, 1, 0));
      directed.push_back(mk(10, 1, 1, 4000, 3800, 1, 1, 0, 1, 0));
      directed.push_back(mk(25, 1, 1, 4000, 3800, 1, 1, 1, 1, 0));
      directed.push_back(mk(65535, 1, 1, 4000, 3800, 1, 1, 1, 1, 0));
      directed.push_back(mk(0, 1, 1, 4000, 3800, 1, 1, 1, 1, 3));
      directed.push_back(mk(5, 1, 1, 4000, 3800, 0, 1, 0, 0, 2));
      directed.push_back(mk(5, 1, 1, 4000, 3800, 1, 1, 0, 0, 0));
      directed.push_back(mk(5, 1, 1, 4000, 3800, 0, 1, 0, 0, 0));
      directed.push_back(mk(5, 1, 1, 4000, 3800, 1, 1, 0, 0, 0));
      directed.push_back(mk(5, 1, 1, 4000, 4000, 1, 1, 0, 0, 0));
      directed.push_back(mk(5, 1, 1, 4000, 4000, 0, 1, 0, 0, 0));
      directed.push_back(mk(500, 1, 1, 4000, 0, 0, 1, 0, 0, 2));
      directed.push_back(mk(1, 1, 1, 4000, 0, 0, 1, 0, 0, 0));
      foreach (directed[i]) send_tick(directed[i], pick_gap());
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: apply_config(500, 100, 950, 5000, 1000);
            1: apply_config(0, 0, 0, 0, 0);
            2: apply_config(65535, 8000, 1000, 65535, 65535);
            3: apply_config($urandom_range(0, 65535), $urandom_range(0, 8000),
                            $urandom_range(0, 1000), $urandom_range(0, 65535),
                            $urandom_range(0, 65535));
            default: apply_config($urandom_range(0, 300), $urandom_range(0, 2000),
                                  $urandom_range(500, 1000), $urandom_range(50, 2000),
                                  $urandom_range(0, 300));
         endcase
         no_gaps = phase == 0;
         for (int n = 0; n < 375; n++) send_tick(random_tick(), pick_gap());
         drain();
      end

      repeat (10) @(negedge clock);
      $display("Sent %0d control ticks under %0d register settings: directed walks of every mode",
               ticks_sent, settings_applied);
      $display("and random drive cycles with faults and link dropouts; %0d results compared.",
               results_checked);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
